// ===== rtl/ctst_pkg.sv =====
// Types, codes and helper constants shared by the timer slot table files.
`timescale 1ns / 1ps
`default_nettype none

package ctst_pkg;

    typedef logic [1:0]         t_mode;
    typedef logic [7:0]         t_handler;
    typedef logic [15:0]        t_arg;
    typedef logic signed [15:0] t_count;
    typedef logic [7:0]         t_class;
    typedef logic [1:0]         t_status;
    typedef logic [3:0]         t_slot;
    typedef logic [4:0]         t_active;

    localparam t_mode MODE_START      = 2'd0;
    localparam t_mode MODE_LENGTHEN   = 2'd1;
    localparam t_mode MODE_EXTINGUISH = 2'd2;
    localparam t_mode MODE_TICK       = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_BAD_CLASS = 2'd3;

    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        t_class   cls;
        t_handler handler;
        t_arg     arg;
        t_count   remaining;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic   hit;
        logic   dec;
        logic   fire;
        t_count sum_rem;
        t_count dec_rem;
    } t_eval;

endpackage

`default_nettype wire

// ===== rtl/ctst_if.sv =====
// Request and result channel interfaces of the timer slot table.
`timescale 1ns / 1ps
`default_nettype none

interface ctst_in_if;
    logic               valid;
    logic               ready;
    ctst_pkg::t_mode    mode;
    ctst_pkg::t_handler handler_id;
    ctst_pkg::t_arg     arg_handle;
    ctst_pkg::t_count   count_value;
    ctst_pkg::t_class   timer_class;

    modport source (
        output valid, mode, handler_id, arg_handle, count_value, timer_class,
        input  ready
    );
    modport sink (
        input  valid, mode, handler_id, arg_handle, count_value, timer_class,
        output ready
    );
endinterface

interface ctst_out_if;
    logic               valid;
    logic               ready;
    ctst_pkg::t_status  status;
    logic               fired;
    ctst_pkg::t_handler fired_handler;
    ctst_pkg::t_arg     fired_arg;
    ctst_pkg::t_slot    slot_index;
    ctst_pkg::t_active  active_count;
    logic               last;

    modport source (
        output valid, status, fired, fired_handler, fired_arg, slot_index,
               active_count, last,
        input  ready
    );
    modport sink (
        input  valid, status, fired, fired_handler, fired_arg, slot_index,
               active_count, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/ctst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ctst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ctst_slot_eval.sv =====
// Per-slot match, saturating lengthen and countdown decision logic.
`timescale 1ns / 1ps
`default_nettype none

module ctst_slot_eval (
    input  wire logic               i_valid,
    input  wire ctst_pkg::t_entry   i_entry,
    input  wire ctst_pkg::t_handler i_handler,
    input  wire ctst_pkg::t_class   i_class,
    input  wire ctst_pkg::t_count   i_amount,
    output ctst_pkg::t_eval         o_eval
);

    logic signed [16:0] sum;
    logic               rem_pos;

    assign sum     = {i_entry.remaining[15], i_entry.remaining} + {i_amount[15], i_amount};
    assign rem_pos = !i_entry.remaining[15] && (i_entry.remaining != 16'sd0);

    always_comb begin
        o_eval.hit  = i_valid && (i_entry.handler == i_handler);
        o_eval.dec  = i_valid && (i_entry.cls == i_class) && rem_pos;
        o_eval.fire = o_eval.dec && (i_entry.remaining == 16'sd1);
        if (sum[16] != sum[15]) begin
            o_eval.sum_rem = sum[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            o_eval.sum_rem = sum[15:0];
        end
        o_eval.dec_rem = i_entry.remaining - 16'sd1;
    end

endmodule

`default_nettype wire

// ===== rtl/countdown_timer_slot_table_core.sv =====
// Top level of the countdown timer slot table.
//
// Requests arrive on i_in (valid/ready); each accepted transaction yields one
// or more result transactions on o_out, the final one with last set.
// One request is worked on at a time; i_in.ready is high while idle.
// Slot payloads live in one RAM with a registered read; occupancy
// is a flip-flop valid bit per slot.
// Start: the result goes out through S_REPORT and the output register
// (free slot found by a priority encoder over the valid bits).
// Lengthen / extinguish: walk the RAM one slot per cycle, stop at the first
// handler match or the last slot, then report through S_REPORT.
// Tick: two RAM walks, one to count expiries so active_count and last are
// known up front, one to decrement, write back and report: fired results
// come out during the second walk, and when nothing fires a single status
// result follows it through S_REPORT.
// Results pass through one output register, so a waiting result never blocks
// acceptance of the next request; a stalled receiver holds the tick walk.
// Reset frees every slot at once and clears the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module countdown_timer_slot_table_core #(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ctst_in_if.sink   i_in,
    ctst_out_if.source o_out
);

    localparam int IDX_W     = $clog2(TIMER_SLOTS);
    localparam int CNT_W     = $clog2(TIMER_SLOTS + 1);
    localparam int RES_LIMIT = (TIMER_SLOTS < ctst_pkg::MAX_RESULTS) ?
                               TIMER_SLOTS : ctst_pkg::MAX_RESULTS;
    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(RES_LIMIT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_COUNT  = 5'b00100,
        S_FIRE   = 5'b01000,
        S_REPORT = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [TIMER_SLOTS-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]       r_occ, n_occ;
    logic                   r_out_valid, n_out_valid;

    ctst_pkg::t_mode        r_mode, n_mode;
    ctst_pkg::t_handler     r_handler, n_handler;
    ctst_pkg::t_count       r_amount, n_amount;
    ctst_pkg::t_class       r_class, n_class;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_fires, n_fires;
    logic [CNT_W-1:0]       r_target, n_target;
    logic [CNT_W-1:0]       r_emitted, n_emitted;
    logic [CNT_W-1:0]       r_active_fin, n_active_fin;
    ctst_pkg::t_status      r_res_status, n_res_status;
    logic [IDX_W-1:0]       r_res_slot, n_res_slot;

    ctst_pkg::t_status      r_out_status, n_out_status;
    logic                   r_out_fired, n_out_fired;
    ctst_pkg::t_handler     r_out_handler, n_out_handler;
    ctst_pkg::t_arg         r_out_arg, n_out_arg;
    ctst_pkg::t_slot        r_out_slot, n_out_slot;
    ctst_pkg::t_active      r_out_active, n_out_active;
    logic                   r_out_last, n_out_last;

    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    ctst_pkg::t_entry                ram_wdata;
    logic                            ram_re;
    logic [IDX_W-1:0]                ram_raddr;
    logic [ctst_pkg::ENTRY_W-1:0]    ram_rdata;
    ctst_pkg::t_entry                rd;
    ctst_pkg::t_eval                 ev;

    logic             out_free;
    logic             idx_last;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] free_idx;
    logic             table_full;
    logic [CNT_W-1:0] fires_all;
    logic             report;

    assign rd       = ctst_pkg::t_entry'(ram_rdata);
    assign out_free = !r_out_valid || o_out.ready;
    assign idx_last = (r_idx == LAST_IDX);
    assign idx_next = IDX_W'(r_idx + 1'b1);
    assign fires_all = CNT_W'(r_fires + CNT_W'(ev.fire));
    assign report    = ev.fire && (r_emitted != r_target);

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.fired         = r_out_fired;
    assign o_out.fired_handler = r_out_handler;
    assign o_out.fired_arg     = r_out_arg;
    assign o_out.slot_index    = r_out_slot;
    assign o_out.active_count  = r_out_active;
    assign o_out.last          = r_out_last;

    ctst_ram #(
        .WIDTH (ctst_pkg::ENTRY_W),
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ctst_slot_eval u_eval (
        .i_valid   (r_valid[r_idx]),
        .i_entry   (rd),
        .i_handler (r_handler),
        .i_class   (r_class),
        .i_amount  (r_amount),
        .o_eval    (ev)
    );

    always_comb begin
        free_idx   = '0;
        table_full = 1'b1;
        for (int k = TIMER_SLOTS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_idx   = IDX_W'(k);
                table_full = 1'b0;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_occ        = r_occ;
        n_mode       = r_mode;
        n_handler    = r_handler;
        n_amount     = r_amount;
        n_class      = r_class;
        n_idx        = r_idx;
        n_fires      = r_fires;
        n_target     = r_target;
        n_emitted    = r_emitted;
        n_active_fin = r_active_fin;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;

        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_status  = r_out_status;
        n_out_fired   = r_out_fired;
        n_out_handler = r_out_handler;
        n_out_arg     = r_out_arg;
        n_out_slot    = r_out_slot;
        n_out_active  = r_out_active;
        n_out_last    = r_out_last;

        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = rd;
        ram_re    = 1'b0;
        ram_raddr = idx_next;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mode    = i_in.mode;
                    n_handler = i_in.handler_id;
                    n_amount  = i_in.count_value;
                    n_class   = i_in.timer_class;
                    n_idx     = '0;
                    n_fires   = '0;
                    ram_raddr = '0;
                    case (i_in.mode)
                        ctst_pkg::MODE_START: begin
                            n_state    = S_REPORT;
                            n_res_slot = '0;
                            if (i_in.timer_class == 8'd0) begin
                                n_res_status = ctst_pkg::ST_BAD_CLASS;
                            end else if (table_full) begin
                                n_res_status = ctst_pkg::ST_FULL;
                            end else begin
                                ram_we              = 1'b1;
                                ram_waddr           = free_idx;
                                ram_wdata.cls       = i_in.timer_class;
                                ram_wdata.handler   = i_in.handler_id;
                                ram_wdata.arg       = i_in.arg_handle;
                                ram_wdata.remaining = i_in.count_value;
                                n_valid[free_idx]   = 1'b1;
                                n_occ               = CNT_W'(r_occ + 1'b1);
                                n_res_status        = ctst_pkg::ST_OK;
                                n_res_slot          = free_idx;
                            end
                        end
                        ctst_pkg::MODE_LENGTHEN, ctst_pkg::MODE_EXTINGUISH: begin
                            ram_re  = 1'b1;
                            n_state = S_SEARCH;
                        end
                        ctst_pkg::MODE_TICK: begin
                            ram_re  = 1'b1;
                            n_state = S_COUNT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_SEARCH: begin
                if (ev.hit) begin
                    if (r_mode == ctst_pkg::MODE_LENGTHEN) begin
                        ram_we              = 1'b1;
                        ram_wdata.remaining = ev.sum_rem;
                    end else begin
                        n_valid[r_idx] = 1'b0;
                        n_occ          = CNT_W'(r_occ - 1'b1);
                    end
                    n_res_status = ctst_pkg::ST_OK;
                    n_res_slot   = r_idx;
                    n_state      = S_REPORT;
                end else if (idx_last) begin
                    n_res_status = ctst_pkg::ST_NOT_FOUND;
                    n_res_slot   = '0;
                    n_state      = S_REPORT;
                end else begin
                    ram_re = 1'b1;
                    n_idx  = idx_next;
                end
            end

            S_COUNT: begin
                if (idx_last) begin
                    n_target     = (fires_all < LIMIT_C) ? fires_all : LIMIT_C;
                    n_active_fin = CNT_W'(r_occ - fires_all);
                    n_emitted    = '0;
                    n_res_status = ctst_pkg::ST_OK;
                    n_res_slot   = '0;
                    ram_re       = 1'b1;
                    ram_raddr    = '0;
                    n_idx        = '0;
                    n_state      = S_FIRE;
                end else begin
                    ram_re  = 1'b1;
                    n_idx   = idx_next;
                    n_fires = fires_all;
                end
            end

            S_FIRE: begin
                if (!report || out_free) begin
                    if (ev.dec) begin
                        ram_we              = 1'b1;
                        ram_wdata.remaining = ev.dec_rem;
                    end
                    if (ev.fire) begin
                        n_valid[r_idx] = 1'b0;
                        n_occ          = CNT_W'(r_occ - 1'b1);
                    end
                    if (report) begin
                        n_out_valid   = 1'b1;
                        n_out_status  = ctst_pkg::ST_OK;
                        n_out_fired   = 1'b1;
                        n_out_handler = rd.handler;
                        n_out_arg     = rd.arg;
                        n_out_slot    = ctst_pkg::t_slot'(r_idx);
                        n_out_active  = ctst_pkg::t_active'(r_active_fin);
                        n_out_last    = (CNT_W'(r_emitted + 1'b1) == r_target);
                        n_emitted     = CNT_W'(r_emitted + 1'b1);
                    end
                    if (idx_last) begin
                        n_state = (r_target == '0) ? S_REPORT : S_IDLE;
                    end else begin
                        ram_re = 1'b1;
                        n_idx  = idx_next;
                    end
                end
            end

            S_REPORT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_fired   = 1'b0;
                    n_out_handler = '0;
                    n_out_arg     = '0;
                    n_out_slot    = ctst_pkg::t_slot'(r_res_slot);
                    n_out_active  = ctst_pkg::t_active'(r_occ);
                    n_out_last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode        <= n_mode;
        r_handler     <= n_handler;
        r_amount      <= n_amount;
        r_class       <= n_class;
        r_idx         <= n_idx;
        r_fires       <= n_fires;
        r_target      <= n_target;
        r_emitted     <= n_emitted;
        r_active_fin  <= n_active_fin;
        r_res_status  <= n_res_status;
        r_res_slot    <= n_res_slot;
        r_out_status  <= n_out_status;
        r_out_fired   <= n_out_fired;
        r_out_handler <= n_out_handler;
        r_out_arg     <= n_out_arg;
        r_out_slot    <= n_out_slot;
        r_out_active  <= n_out_active;
        r_out_last    <= n_out_last;
    end

endmodule

`default_nettype wire

// ===== bench/tb_countdown_timer_slot_table_core.sv =====
// Self-checking testbench for the countdown timer slot table core.
`timescale 1ns / 1ps

module tb_countdown_timer_slot_table_core;

    localparam int SLOTS        = 16;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 150;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        ctst_pkg::t_status  status;
        logic               fired;
        ctst_pkg::t_handler handler;
        ctst_pkg::t_arg     arg;
        ctst_pkg::t_slot    slot;
        ctst_pkg::t_active  active;
        logic               last;
    } t_timer_result;

    logic i_clk;
    logic i_rst_n;

    ctst_in_if  req_if ();
    ctst_out_if res_if ();

    countdown_timer_slot_table_core #(
        .TIMER_SLOTS(SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_if),
        .o_out  (res_if)
    );

    ctst_pkg::t_class   tbl_class     [SLOTS];
    ctst_pkg::t_handler tbl_handler   [SLOTS];
    ctst_pkg::t_arg     tbl_arg       [SLOTS];
    ctst_pkg::t_count   tbl_remaining [SLOTS];
    int                 tbl_active;

    t_timer_result expected_results[$];

    int  mismatch_count;
    int  result_count;
    int  cycle_count;
    bit  tx_idle;
    bit  rx_idle;
    int  rx_hold;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] result %0d %s: got %0h expected %0h",
                     $realtime, result_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    task automatic predict_request(input ctst_pkg::t_mode m, input ctst_pkg::t_handler h,
                                   input ctst_pkg::t_arg a, input ctst_pkg::t_count c,
                                   input ctst_pkg::t_class k);
        t_timer_result r;
        t_timer_result fired_q[$];
        int idx;
        int sum;
        r   = '0;
        idx = -1;
        case (m)
            ctst_pkg::MODE_START: begin
                if (k == 0) begin
                    r.status = ctst_pkg::ST_BAD_CLASS;
                end else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (idx < 0 && tbl_class[i] == 0)
                            idx = i;
                    if (idx < 0) begin
                        r.status = ctst_pkg::ST_FULL;
                    end else begin
                        tbl_class[idx]     = k;
                        tbl_handler[idx]   = h;
                        tbl_arg[idx]       = a;
                        tbl_remaining[idx] = c;
                        tbl_active++;
                        r.slot = ctst_pkg::t_slot'(idx);
                    end
                end
                r.active = ctst_pkg::t_active'(tbl_active);
                r.last   = 1'b1;
                expected_results.push_back(r);
            end
            ctst_pkg::MODE_LENGTHEN, ctst_pkg::MODE_EXTINGUISH: begin
                for (int i = 0; i < SLOTS; i++)
                    if (idx < 0 && tbl_class[i] != 0 && tbl_handler[i] == h)
                        idx = i;
                if (idx < 0) begin
                    r.status = ctst_pkg::ST_NOT_FOUND;
                end else if (m == ctst_pkg::MODE_LENGTHEN) begin
                    sum = int'(tbl_remaining[idx]) + int'(c);
                    if (sum > 32767)
                        sum = 32767;
                    if (sum < -32768)
                        sum = -32768;
                    tbl_remaining[idx] = ctst_pkg::t_count'(sum);
                    r.slot = ctst_pkg::t_slot'(idx);
                end else begin
                    tbl_class[idx]     = '0;
                    tbl_remaining[idx] = '0;
                    tbl_active--;
                    r.slot = ctst_pkg::t_slot'(idx);
                end
                r.active = ctst_pkg::t_active'(tbl_active);
                r.last   = 1'b1;
                expected_results.push_back(r);
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_class[i] != 0 && tbl_class[i] == k &&
                        tbl_remaining[i] > 0) begin
                        tbl_remaining[i] = tbl_remaining[i] - 16'sd1;
                        if (tbl_remaining[i] == 0) begin
                            tbl_class[i] = '0;
                            tbl_active--;
                            if (fired_q.size() < ctst_pkg::MAX_RESULTS) begin
                                r         = '0;
                                r.fired   = 1'b1;
                                r.handler = tbl_handler[i];
                                r.arg     = tbl_arg[i];
                                r.slot    = ctst_pkg::t_slot'(i);
                                fired_q.push_back(r);
                            end
                        end
                    end
                end
                if (fired_q.size() == 0) begin
                    r        = '0;
                    r.active = ctst_pkg::t_active'(tbl_active);
                    r.last   = 1'b1;
                    expected_results.push_back(r);
                end else begin
                    foreach (fired_q[j]) begin
                        r        = fired_q[j];
                        r.active = ctst_pkg::t_active'(tbl_active);
                        r.last   = (j == fired_q.size() - 1);
                        expected_results.push_back(r);
                    end
                end
            end
        endcase
    endtask

    task automatic send_request(input ctst_pkg::t_mode m, input ctst_pkg::t_handler h,
                                input ctst_pkg::t_arg a, input ctst_pkg::t_count c,
                                input ctst_pkg::t_class k);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.mode        <= m;
        req_if.handler_id  <= h;
        req_if.arg_handle  <= a;
        req_if.count_value <= c;
        req_if.timer_class <= k;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        predict_request(m, h, a, c, k);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_request(ctst_pkg::MODE_TICK, 8'h00, 16'h0000, 16'sd0, 8'h00);
        send_request(ctst_pkg::MODE_START, 8'hFF, 16'hFFFF, 16'sd5, 8'h00);
        send_request(ctst_pkg::MODE_EXTINGUISH, 8'h05, 16'h0000, 16'sd0, 8'h01);
        wait_drained();
    endtask

    task automatic test_fill_and_expire();
        ctst_pkg::t_count c;
        for (int i = 0; i < SLOTS; i++) begin
            c = (i == 1) ? 16'sd0 : (i == 2) ? -16'sd32768 : 16'sd1;
            send_request(ctst_pkg::MODE_START, ctst_pkg::t_handler'(i * 17),
                         (i % 2) ? 16'hFFFF : 16'h0000, c, 8'hA5);
        end
        send_request(ctst_pkg::MODE_START, 8'h42, 16'h1234, 16'sd32767, 8'hFF);
        send_request(ctst_pkg::MODE_LENGTHEN, 8'hFF, 16'h0000, 16'sd32767, 8'h00);
        send_request(ctst_pkg::MODE_LENGTHEN, 8'h00, 16'h0000, -16'sd32768, 8'h00);
        send_request(ctst_pkg::MODE_LENGTHEN, 8'h00, 16'h0000, -16'sd32768, 8'h00);
        send_request(ctst_pkg::MODE_TICK, 8'h00, 16'h0000, 16'sd0, 8'hA5);
        send_request(ctst_pkg::MODE_TICK, 8'h00, 16'h0000, 16'sd0, 8'h00);
        send_request(ctst_pkg::MODE_EXTINGUISH, 8'hFF, 16'h0000, 16'sd0, 8'h00);
        send_request(ctst_pkg::MODE_EXTINGUISH, 8'h00, 16'h0000, 16'sd0, 8'h00);
        send_request(ctst_pkg::MODE_EXTINGUISH, 8'h11, 16'h0000, 16'sd0, 8'h00);
        send_request(ctst_pkg::MODE_EXTINGUISH, 8'h22, 16'h0000, 16'sd0, 8'h00);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        int                 r;
        ctst_pkg::t_mode    m;
        ctst_pkg::t_handler h;
        ctst_pkg::t_count   c;
        ctst_pkg::t_class   k;
        for (int i = 0; i < n_items; i++) begin
            if (i % 25 == 0) begin
                case ((i / 25) % 3)
                    0: begin tx_idle = 1'b1; rx_idle = 1'b1; end
                    1: begin tx_idle = 1'b0; rx_idle = 1'b0; end
                    default: begin
                        tx_idle = $urandom_range(0, 1);
                        rx_idle = $urandom_range(0, 1);
                    end
                endcase
            end
            r = $urandom_range(0, 99);
            h = ($urandom_range(0, 99) < 85) ?
                ctst_pkg::t_handler'($urandom_range(0, 7)) :
                ctst_pkg::t_handler'($urandom_range(0, 255));
            k = ($urandom_range(0, 19) != 0) ?
                ctst_pkg::t_class'($urandom_range(1, 3)) :
                ctst_pkg::t_class'($urandom_range(0, 255));
            if (r < 38) begin
                m = ctst_pkg::MODE_START;
                r = $urandom_range(0, 9);
                if (r < 7)
                    c = ctst_pkg::t_count'($urandom_range(1, 6));
                else if (r < 8)
                    c = ctst_pkg::t_count'(int'($urandom_range(0, 3)) - 3);
                else
                    c = ctst_pkg::t_count'($urandom_range(0, 65535));
            end else if (r < 68) begin
                m = (r < 55) ? ctst_pkg::MODE_LENGTHEN : ctst_pkg::MODE_EXTINGUISH;
                c = ($urandom_range(0, 4) != 0) ?
                    ctst_pkg::t_count'(int'($urandom_range(0, 9)) - 3) :
                    ctst_pkg::t_count'($urandom_range(0, 65535));
            end else begin
                m = ctst_pkg::MODE_TICK;
                c = ctst_pkg::t_count'($urandom_range(0, 65535));
            end
            send_request(m, h, ctst_pkg::t_arg'($urandom_range(0, 65535)), c, k);
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold = 400;
        for (int i = 0; i < 20; i++) begin
            if (i % 3 == 2)
                send_request(ctst_pkg::MODE_TICK, 8'h00, 16'h0000, 16'sd0, 8'h07);
            else
                send_request(ctst_pkg::MODE_START,
                             ctst_pkg::t_handler'($urandom_range(0, 255)),
                             ctst_pkg::t_arg'($urandom_range(0, 65535)),
                             ctst_pkg::t_count'($urandom_range(1, 2)), 8'h07);
        end
        wait_drained();
    endtask

    initial begin
        int stall;
        res_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = rx_idle ? $urandom_range(0, 16) : 0;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", res_if.slot_index, 0);
            end else begin
                want = expected_results.pop_front();
                check_field("status", res_if.status, want.status);
                check_field("fired", res_if.fired, want.fired);
                check_field("fired_handler", res_if.fired_handler, want.handler);
                check_field("fired_arg", res_if.fired_arg, want.arg);
                check_field("slot_index", res_if.slot_index, want.slot);
                check_field("active_count", res_if.active_count, want.active);
                check_field("last", res_if.last, want.last);
            end
            result_count++;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        result_count   = 0;
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        rx_hold        = 0;
        tbl_active     = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_class[i]     = '0;
            tbl_handler[i]   = '0;
            tbl_arg[i]       = '0;
            tbl_remaining[i] = '0;
        end
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.mode        <= ctst_pkg::MODE_START;
        req_if.handler_id  <= '0;
        req_if.arg_handle  <= '0;
        req_if.count_value <= '0;
        req_if.timer_class <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_fill_and_expire();
        test_random_traffic(RANDOM_ITEMS);
        test_output_backpressure();

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
